// ===== sv/hcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_pkg
// Types and codes shared by the height color ramp modules.
// ----------------------------------------------------------------------------
package hcr_pkg;

  typedef enum logic {
    OP_STOP_WRITE = 1'b0,
    OP_MAP        = 1'b1
  } hcr_op_e;

  typedef enum logic [1:0] {
    REG_LOWER_COLOR = 2'd0,
    REG_UPPER_COLOR = 2'd1,
    REG_STOP_COUNT  = 2'd2
  } hcr_reg_e;

  localparam logic [31:0] ColorReset = 32'h0000_00FF;
  localparam logic [3:0]  CountReset = 4'd1;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         stop_index;
    logic signed [15:0] stop_height;
    logic [31:0]        stop_color;
    logic signed [15:0] sample_height;
  } hcr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } hcr_out_t;

  typedef struct packed {
    logic               en;
    logic signed [15:0] height;
    logic [31:0]        color;
  } hcr_wr_t;

  typedef struct packed {
    logic signed [15:0] h;
    logic               head;
    logic               below;
    logic               over;
    logic               found;
    logic               first;
    logic signed [15:0] prev_h;
    logic [31:0]        prev_c;
    logic signed [15:0] h0;
    logic [31:0]        c0;
    logic signed [15:0] h1;
    logic [31:0]        c1;
  } hcr_tok_t;

  typedef struct packed {
    logic [7:0]  a;
    logic        neg;
    logic [23:0] prod;
  } hcr_chan_t;

endpackage

// ===== sv/hcr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_cell
// One stop of the ramp: holds its height and color and checks the passing
// sample against them.
// ----------------------------------------------------------------------------
module hcr_cell (
  input  logic              clk_i,
  input  hcr_pkg::hcr_wr_t  wr_i,
  input  logic              active_i,
  input  logic              last_i,
  input  hcr_pkg::hcr_tok_t tok_i,
  output hcr_pkg::hcr_tok_t tok_o
);

  logic signed [15:0] height_q;
  logic [31:0]        color_q;
  hcr_pkg::hcr_tok_t  tok_d, tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      height_q <= wr_i.height;
      color_q  <= wr_i.color;
    end
    tok_q <= tok_d;
  end

  always_comb begin
    tok_d        = tok_i;
    tok_d.head   = 1'b0;
    tok_d.prev_h = height_q;
    tok_d.prev_c = color_q;
    if (active_i && !tok_i.found && (tok_i.h <= height_q)) begin
      tok_d.found = 1'b1;
      tok_d.first = tok_i.head;
      tok_d.h0    = tok_i.prev_h;
      tok_d.c0    = tok_i.prev_c;
      tok_d.h1    = height_q;
      tok_d.c1    = color_q;
    end
    if (tok_i.head && (tok_i.h < height_q)) begin
      tok_d.below = 1'b1;
    end
    if (last_i && (tok_i.h > height_q)) begin
      tok_d.over = 1'b1;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/hcr_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcr_interp
// Four-channel floored interpolation: restoring division, one quotient bit
// per cycle, eight quotient bits per channel.
// ----------------------------------------------------------------------------
module hcr_interp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  hcr_pkg::hcr_chan_t chan_i [4],
  input  logic [15:0]        den_i,
  output logic               done_o,
  output logic [31:0]        color_o
);

  logic               busy_q, done_q;
  logic [2:0]         bit_q;
  logic [15:0]        den_q;
  logic [23:0]        rem_q [4];
  logic [7:0]         quo_q [4];
  logic [7:0]         a_q   [4];
  logic               neg_q [4];
  logic [23:0]        trial;
  logic               ge    [4];

  assign trial = {8'b0, den_q} << bit_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ge[c] = rem_q[c] >= trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= 3'd7;
      end else if (busy_q) begin
        bit_q <= bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int c = 0; c < 4; c++) begin
        rem_q[c] <= chan_i[c].prod;
        quo_q[c] <= 8'd0;
        a_q[c]   <= chan_i[c].a;
        neg_q[c] <= chan_i[c].neg;
      end
    end else if (busy_q) begin
      for (int c = 0; c < 4; c++) begin
        if (ge[c]) begin
          rem_q[c]        <= rem_q[c] - trial;
          quo_q[c][bit_q] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (neg_q[c]) begin
        color_o[31-8*c -: 8] = a_q[c] - quo_q[c] - {7'b0, (rem_q[c] != 24'd0)};
      end else begin
        color_o[31-8*c -: 8] = a_q[c] + quo_q[c];
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== sv/height_color_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_color_ramp_top
// Maps signed elevation samples to RGBA through a table of height/color stops.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i): opcode selects a stop
// write, which loads one cell of the stop chain and gives no result, or a
// map of sample_height, which gives one RGBA transfer on the output channel.
// Configuration channel: lower_color, upper_color and stop_count, to be
// written while the block is idle (not enforced); cfg_ready_o is always high.
// One item is in flight at a time. A stop write leaves the block idle. A map
// walks the sample down the chain of MAX_STOPS cells, one cell per cycle,
// then an evaluate state; an interpolated color adds a divider load, eight
// bit-serial divider steps and a done strobe; the result register follows.
// The output register holds the result until out_ready_i; the next item is
// taken while it waits, but a new result holds until the register frees.
// Reset clears control state and restores the configuration registers;
// stops hold nothing defined until written.
// ----------------------------------------------------------------------------
module height_color_ramp_top #(
  parameter int MAX_STOPS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hcr_pkg::hcr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hcr_pkg::hcr_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int CntW = $clog2(MAX_STOPS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q;
  logic [31:0]         lower_q, upper_q;
  logic [3:0]          count_q;
  logic [31:0]         color_q;
  logic                out_valid_q;
  hcr_pkg::hcr_out_t   out_q;
  hcr_pkg::hcr_tok_t   tok [MAX_STOPS+1];
  hcr_pkg::hcr_tok_t   fin_q;
  hcr_pkg::hcr_chan_t  chan_q [4];
  logic [15:0]         den_q;
  logic                start_q;
  logic                div_done;
  logic [31:0]         div_color;
  logic                in_fire, map_fire, wr_fire, out_free;
  logic [3:0]          n_eff;
  logic signed [16:0]  t_full, den_full;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign map_fire    = in_fire && (in_data_i.opcode == hcr_pkg::OP_MAP);
  assign wr_fire     = in_fire && (in_data_i.opcode == hcr_pkg::OP_STOP_WRITE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign n_eff       = (count_q == 4'd0) ? 4'd1 : count_q;

  always_comb begin
    tok[0]        = '0;
    tok[0].h      = in_data_i.sample_height;
    tok[0].head   = 1'b1;
  end

  for (genvar k = 0; k < MAX_STOPS; k++) begin : g_cell
    hcr_pkg::hcr_wr_t wr;
    logic             active, last;
    assign wr.en     = wr_fire && (32'(in_data_i.stop_index) == k);
    assign wr.height = in_data_i.stop_height;
    assign wr.color  = in_data_i.stop_color;
    assign active    = (k == 0) || (32'(count_q) > k);
    assign last      = (k == MAX_STOPS - 1) ? (32'(n_eff) >= MAX_STOPS)
                                            : (32'(n_eff) == k + 1);
    hcr_cell u_cell (
      .clk_i    (clk_i),
      .wr_i     (wr),
      .active_i (active),
      .last_i   (last),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1])
    );
  end

  assign t_full   = 17'(fin_q.h) - 17'(fin_q.h0);
  assign den_full = 17'(fin_q.h1) - 17'(fin_q.h0);

  hcr_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .chan_i  (chan_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .color_o (div_color)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (map_fire) state_d = ST_WALK;
      ST_WALK: if (cnt_q == CntW'(MAX_STOPS - 1)) state_d = ST_EVAL;
      ST_EVAL: begin
        if (fin_q.below || fin_q.over || fin_q.first) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lower_q     <= hcr_pkg::ColorReset;
      upper_q     <= hcr_pkg::ColorReset;
      count_q     <= hcr_pkg::CountReset;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          hcr_pkg::REG_LOWER_COLOR: lower_q <= cfg_data_i;
          hcr_pkg::REG_UPPER_COLOR: upper_q <= cfg_data_i;
          hcr_pkg::REG_STOP_COUNT:  count_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (map_fire) begin
        cnt_q <= '0;
      end else if (state_q == ST_WALK) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_EVAL && state_d == ST_DIV) begin
        start_q <= 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WALK && cnt_q == CntW'(MAX_STOPS - 1)) begin
      fin_q <= tok[MAX_STOPS];
    end
    if (state_q == ST_EVAL) begin
      den_q <= den_full[15:0];
      for (int c = 0; c < 4; c++) begin
        logic [7:0]        a, b;
        logic signed [8:0] d;
        logic [7:0]        mag;
        a   = fin_q.c0[31-8*c -: 8];
        b   = fin_q.c1[31-8*c -: 8];
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        mag = d[8] ? 8'(-d) : d[7:0];
        chan_q[c].a    <= a;
        chan_q[c].neg  <= d[8];
        chan_q[c].prod <= mag * t_full[15:0];
      end
      if (fin_q.below) begin
        color_q <= lower_q;
      end else if (fin_q.over) begin
        color_q <= upper_q;
      end else begin
        color_q <= fin_q.c1;
      end
    end
    if (state_q == ST_DIV && div_done) begin
      color_q <= div_color;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= color_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
